// File: sv/jsu_pkg.sv
package jsu_pkg;

  // Character codes
  localparam logic [7:0] CH_QUOTE     = 8'h22;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_B         = 8'h62;
  localparam logic [7:0] CH_F         = 8'h66;
  localparam logic [7:0] CH_N         = 8'h6E;
  localparam logic [7:0] CH_R         = 8'h72;
  localparam logic [7:0] CH_T         = 8'h74;
  localparam logic [7:0] CH_U         = 8'h75;

  // Control bytes produced by the short escapes
  localparam logic [7:0] CTL_BS = 8'h08;
  localparam logic [7:0] CTL_FF = 8'h0C;
  localparam logic [7:0] CTL_LF = 8'h0A;
  localparam logic [7:0] CTL_CR = 8'h0D;
  localparam logic [7:0] CTL_HT = 8'h09;

  // Number of hex digit bytes that follow \u
  localparam logic [2:0] HEX_DIGITS = 3'd4;

  // Decoder mode, one-hot
  typedef enum logic [2:0] {
    MODE_NORMAL = 3'b001,
    MODE_ESCAPE = 3'b010,
    MODE_HEX    = 3'b100
  } mode_t;

  // One result item
  typedef struct packed {
    logic [7:0] data;
    logic       valid;
    logic       last;
  } res_t;

  // Hex digit decode: bit 4 set when the byte is a hex digit
  function automatic logic [4:0] hex_nibble(input logic [7:0] c);
    logic [7:0] t;
    t = 8'h00;
    case (c) inside
      [8'h30:8'h39]: begin
        t = c - 8'h30;
        return {1'b1, t[3:0]};
      end
      [8'h61:8'h66]: begin
        t = c - 8'h57;
        return {1'b1, t[3:0]};
      end
      [8'h41:8'h46]: begin
        t = c - 8'h37;
        return {1'b1, t[3:0]};
      end
      default: return 5'd0;
    endcase
  endfunction

  // Short escape map; everything else stands for itself
  function automatic logic [7:0] escape_map(input logic [7:0] c);
    case (c)
      CH_B:    return CTL_BS;
      CH_F:    return CTL_FF;
      CH_N:    return CTL_LF;
      CH_R:    return CTL_CR;
      CH_T:    return CTL_HT;
      default: return c;
    endcase
  endfunction

endpackage

// File: sv/jsu_core.sv
module jsu_core (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          take,
  input  logic [7:0]    in_byte,
  input  logic          in_last,
  output jsu_pkg::res_t res
);
  import jsu_pkg::*;

  logic       at_start_r, at_start_nxt;
  mode_t      mode_r, mode_nxt;
  logic [2:0] hex_left_r, hex_left_nxt;
  logic [7:0] hex_value_r, hex_value_nxt;
  logic       hex_stopped_r, hex_stopped_nxt;

  logic       drop;
  logic [4:0] nib;
  logic       ov;
  logic [7:0] ob;

  assign drop = (in_byte == CH_QUOTE) && (in_last || at_start_r);
  assign nib  = hex_nibble(in_byte);

  // Next state and result for the byte at the port
  always_comb begin
    mode_nxt        = mode_r;
    hex_left_nxt    = hex_left_r;
    hex_value_nxt   = hex_value_r;
    hex_stopped_nxt = hex_stopped_r;
    ov              = 1'b0;
    ob              = 8'h00;
    case (mode_r)
      MODE_HEX: begin
        if (!drop) begin
          if (!nib[4]) begin
            hex_stopped_nxt = 1'b1;
          end else if (!hex_stopped_r) begin
            hex_value_nxt = {hex_value_r[3:0], nib[3:0]};
          end
          hex_left_nxt = hex_left_r - 3'd1;
        end
        if (hex_left_nxt == 3'd0 || in_last) begin
          ov           = 1'b1;
          ob           = hex_value_nxt;
          mode_nxt     = MODE_NORMAL;
          hex_left_nxt = 3'd0;
        end
      end
      MODE_ESCAPE: begin
        if (!drop) begin
          if (in_byte == CH_U) begin
            mode_nxt        = MODE_HEX;
            hex_left_nxt    = HEX_DIGITS;
            hex_value_nxt   = 8'h00;
            hex_stopped_nxt = 1'b0;
            ov              = in_last;
          end else begin
            ov       = 1'b1;
            ob       = escape_map(in_byte);
            mode_nxt = MODE_NORMAL;
          end
        end
      end
      default: begin
        if (!drop) begin
          if (in_byte == CH_BACKSLASH) begin
            mode_nxt = MODE_ESCAPE;
          end else begin
            ov = 1'b1;
            ob = in_byte;
          end
        end
      end
    endcase
    at_start_nxt = 1'b0;
    // End of string returns everything to its reset values
    if (in_last) begin
      at_start_nxt    = 1'b1;
      mode_nxt        = MODE_NORMAL;
      hex_left_nxt    = 3'd0;
      hex_value_nxt   = 8'h00;
      hex_stopped_nxt = 1'b0;
    end
  end

  assign res.data  = ov ? ob : 8'h00;
  assign res.valid = ov;
  assign res.last  = in_last;

  // Decoder state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      at_start_r    <= 1'b1;
      mode_r        <= MODE_NORMAL;
      hex_left_r    <= 3'd0;
      hex_value_r   <= 8'h00;
      hex_stopped_r <= 1'b0;
    end else if (take) begin
      at_start_r    <= at_start_nxt;
      mode_r        <= mode_nxt;
      hex_left_r    <= hex_left_nxt;
      hex_value_r   <= hex_value_nxt;
      hex_stopped_r <= hex_stopped_nxt;
    end
  end

endmodule

// File: sv/jsu_outq.sv
module jsu_outq (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  jsu_pkg::res_t push_res,
  output logic          full,
  input  logic          pop,
  output logic          head_vld,
  output jsu_pkg::res_t head
);
  import jsu_pkg::*;

  res_t       head_r, head_nxt;
  res_t       skid_r, skid_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  // Head register plus one skid entry
  always_comb begin
    head_nxt = head_r;
    skid_nxt = skid_r;
    cnt_nxt  = cnt_r;
    case (cnt_r)
      2'd0: begin
        if (push) begin
          head_nxt = push_res;
          cnt_nxt  = 2'd1;
        end
      end
      2'd1: begin
        if (push && pop) begin
          head_nxt = push_res;
        end else if (push) begin
          skid_nxt = push_res;
          cnt_nxt  = 2'd2;
        end else if (pop) begin
          cnt_nxt = 2'd0;
        end
      end
      default: begin
        if (pop) begin
          head_nxt = skid_r;
          cnt_nxt  = 2'd1;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    head_r <= head_nxt;
    skid_r <= skid_nxt;
  end

  assign full     = cnt_r[1];
  assign head_vld = (cnt_r != 2'd0);
  assign head     = head_r;

endmodule

// File: sv/json_string_unescaper.sv
// JSON string unescaper: takes one byte of an escaped string per item and
// returns exactly one result per item, registered in the output buffer,
// at one item per clock while in_stall is low. The rate is set by the decoder's
// mode/hex registers, which update once per byte. A two-entry output buffer
// keeps taking items while a result waits; in_stall rises only when both
// entries are full. out_valid marks results that carry a byte, out_last
// echoes in_last, and decoding state clears after each last byte.
module json_string_unescaper (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output logic       out_item_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       out_valid,
  output logic       out_last
);
  import jsu_pkg::*;

  logic take;
  logic pop;
  logic full;
  res_t res;
  res_t head;

  assign take = in_valid && !full;
  assign pop  = out_item_valid && !out_stall;

  // Byte decoder with its mode registers
  jsu_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .take    (take),
    .in_byte (in_byte),
    .in_last (in_last),
    .res     (res)
  );

  // Result register with skid entry
  jsu_outq u_outq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (take),
    .push_res (res),
    .full     (full),
    .pop      (pop),
    .head_vld (out_item_valid),
    .head     (head)
  );

  assign in_stall  = full;
  assign out_byte  = head.data;
  assign out_valid = head.valid;
  assign out_last  = head.last;

endmodule

// File: sv/jsu_checker.sv
module jsu_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic       in_last,
  input logic       out_item_valid,
  input logic       out_stall,
  input logic [7:0] out_byte,
  input logic       out_valid,
  input logic       out_last
);

  // A result without a byte carries zero
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_item_valid && !out_valid |-> out_byte == 8'h00)
    else $error("result without byte has nonzero data");

  // Back-pressure only when a result is waiting
  a_stall_has_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_item_valid)
    else $error("input stalled with no pending result");

  // After a taken item, a result is waiting in the next cycle
  a_take_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> out_item_valid)
    else $error("taken item produced no result");

  // With the head free to move, a taken item lands at the head with its last flag
  a_last_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && !(out_item_valid && out_stall)
      |=> out_last == $past(in_last))
    else $error("result last flag does not follow the taken item");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_item_valid && out_stall |=> out_item_valid && $stable(out_byte)
      && $stable(out_valid) && $stable(out_last))
    else $error("stalled result changed");

endmodule

bind json_string_unescaper jsu_checker u_jsu_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .in_last        (in_last),
  .out_item_valid (out_item_valid),
  .out_stall      (out_stall),
  .out_byte       (out_byte),
  .out_valid      (out_valid),
  .out_last       (out_last)
);

// File: dv/tb_json_string_unescaper.sv
module tb_json_string_unescaper;
  timeunit 1ns;
  timeprecision 1ps;

  import jsu_pkg::*;

  localparam int RAND_ITEMS  = 1100;
  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_AT     = 400;
  localparam int HOLD_CYCLES = 64;
  localparam int NUM_ROWS    = 30;

  // One escaped input byte, with an optional hand-written expectation
  typedef struct packed {
    logic [7:0] b;
    logic       last;
    logic       fixed;
    logic [7:0] want_byte;
    logic       want_valid;
  } esc_item_t;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] in_byte;
  logic       in_last;
  logic       out_item_valid;
  logic       out_stall;
  logic [7:0] out_byte;
  logic       out_valid;
  logic       out_last;

  // expectation that rides along with the item on the input port
  logic in_fixed;
  res_t in_want;

  esc_item_t escaped_q[$];
  res_t      unescaped_q[$];

  int errors     = 0;
  int n_in       = 0;
  int n_out      = 0;
  int cycles     = 0;
  int quiet_left = 0;
  bit hold_off   = 1'b0;
  bit held       = 1'b0;

  // decoder state mirror
  logic       dec_first;
  mode_t      dec_mode;
  logic [2:0] hex_cnt;
  logic [7:0] hex_acc;
  logic       hex_stop;

  // Directed items: quotes, byte extremes, every escape, \u cases, end-of-string cases
  esc_item_t directed_rows [NUM_ROWS] = '{
    '{CH_QUOTE,     1'b0, 1'b1, 8'h00, 1'b0},  // leading quote dropped
    '{8'h00,        1'b0, 1'b1, 8'h00, 1'b1},
    '{8'hFF,        1'b0, 1'b1, 8'hFF, 1'b1},
    '{CH_BACKSLASH, 1'b0, 1'b1, 8'h00, 1'b0},
    '{CH_B,         1'b0, 1'b0, 8'h00, 1'b0},
    '{CH_BACKSLASH, 1'b0, 1'b0, 8'h00, 1'b0},
    '{CH_F,         1'b0, 1'b0, 8'h00, 1'b0},
    '{CH_BACKSLASH, 1'b0, 1'b0, 8'h00, 1'b0},
    '{CH_N,         1'b0, 1'b0, 8'h00, 1'b0},
    '{CH_BACKSLASH, 1'b0, 1'b0, 8'h00, 1'b0},
    '{CH_R,         1'b0, 1'b0, 8'h00, 1'b0},
    '{CH_BACKSLASH, 1'b0, 1'b0, 8'h00, 1'b0},
    '{CH_T,         1'b0, 1'b0, 8'h00, 1'b0},
    '{CH_BACKSLASH, 1'b0, 1'b0, 8'h00, 1'b0},
    '{CH_QUOTE,     1'b0, 1'b0, 8'h00, 1'b0},  // escaped quote mid-string
    '{CH_BACKSLASH, 1'b0, 1'b0, 8'h00, 1'b0},
    '{CH_BACKSLASH, 1'b0, 1'b0, 8'h00, 1'b0},
    '{CH_BACKSLASH, 1'b0, 1'b0, 8'h00, 1'b0},
    '{CH_U,         1'b0, 1'b0, 8'h00, 1'b0},
    '{8'h41,        1'b0, 1'b0, 8'h00, 1'b0},  // 'A'
    '{8'h62,        1'b0, 1'b0, 8'h00, 1'b0},  // 'b'
    '{8'h47,        1'b0, 1'b0, 8'h00, 1'b0},  // 'G' stops the digits
    '{8'h31,        1'b0, 1'b0, 8'h00, 1'b0},  // ignored digit
    '{CH_BACKSLASH, 1'b0, 1'b0, 8'h00, 1'b0},
    '{CH_QUOTE,     1'b1, 1'b1, 8'h00, 1'b0},  // escaped quote at end is still dropped
    '{CH_QUOTE,     1'b1, 1'b1, 8'h00, 1'b0},  // lone quote
    '{CH_BACKSLASH, 1'b0, 1'b0, 8'h00, 1'b0},
    '{CH_U,         1'b0, 1'b0, 8'h00, 1'b0},
    '{8'h37,        1'b1, 1'b0, 8'h00, 1'b0},  // cut-off \u
    '{CH_BACKSLASH, 1'b1, 1'b1, 8'h00, 1'b0}   // dangling backslash
  };

  json_string_unescaper uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_byte        (in_byte),
    .in_last        (in_last),
    .out_item_valid (out_item_valid),
    .out_stall      (out_stall),
    .out_byte       (out_byte),
    .out_valid      (out_valid),
    .out_last       (out_last)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic void clear_decoder();
    dec_first = 1'b1;
    dec_mode  = MODE_NORMAL;
    hex_cnt   = 3'd0;
    hex_acc   = 8'h00;
    hex_stop  = 1'b0;
  endfunction

  function automatic int hex_digit_val(input logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return int'(c) - 'h30;
    if (c >= 8'h61 && c <= 8'h66) return int'(c) - 'h61 + 10;
    if (c >= 8'h41 && c <= 8'h46) return int'(c) - 'h41 + 10;
    return -1;
  endfunction

  // Advance the decoder mirror by one byte and return its result
  function automatic res_t unescape_byte(input logic [7:0] c, input logic last);
    res_t r;
    logic drop;
    int   d;
    r      = '0;
    r.last = last;
    drop   = (c == CH_QUOTE) && (last || dec_first);
    case (dec_mode)
      MODE_HEX: begin
        if (!drop) begin
          d = hex_digit_val(c);
          if (d < 0) hex_stop = 1'b1;
          else if (!hex_stop) hex_acc = {hex_acc[3:0], 4'(d)};
          hex_cnt = hex_cnt - 3'd1;
        end
        if (hex_cnt == 3'd0 || last) begin
          r.valid  = 1'b1;
          r.data   = hex_acc;
          dec_mode = MODE_NORMAL;
          hex_cnt  = 3'd0;
        end
      end
      MODE_ESCAPE: begin
        if (!drop) begin
          if (c == CH_U) begin
            dec_mode = MODE_HEX;
            hex_cnt  = HEX_DIGITS;
            hex_acc  = 8'h00;
            hex_stop = 1'b0;
            if (last) r.valid = 1'b1;
          end else begin
            r.valid = 1'b1;
            case (c)
              CH_B:    r.data = CTL_BS;
              CH_F:    r.data = CTL_FF;
              CH_N:    r.data = CTL_LF;
              CH_R:    r.data = CTL_CR;
              CH_T:    r.data = CTL_HT;
              default: r.data = c;
            endcase
            dec_mode = MODE_NORMAL;
          end
        end
      end
      default: begin
        if (!drop) begin
          if (c == CH_BACKSLASH) dec_mode = MODE_ESCAPE;
          else begin
            r.valid = 1'b1;
            r.data  = c;
          end
        end
      end
    endcase
    dec_first = 1'b0;
    if (last) clear_decoder();
    return r;
  endfunction

  // Mostly zero gaps, some short, a few long, and now and then a quiet run
  function automatic int next_gap();
    int r;
    if (quiet_left > 0) begin
      quiet_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      quiet_left = $urandom_range(20, 60);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // Random strings: mostly well-formed with random content, some noise
  task automatic build_random_strings();
    logic [7:0] s[$];
    int    kind;
    int    nseg;
    int    i;
    int    j;
    int    start;
    bit    cut;
    string hexch = "0123456789abcdefABCDEF";
    start = escaped_q.size();
    while (escaped_q.size() - start < RAND_ITEMS) begin
      s.delete();
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 6)) s.push_back(8'($urandom));
      end else begin
        cut = 1'b0;
        if ($urandom_range(0, 3) != 0) s.push_back(CH_QUOTE);
        nseg = $urandom_range(0, 6);
        for (i = 0; i < nseg && !cut; i++) begin
          kind = $urandom_range(0, 9);
          if (kind < 4) begin
            s.push_back(8'($urandom));
          end else if (kind < 7) begin
            s.push_back(CH_BACKSLASH);
            case ($urandom_range(0, 8))
              0:       s.push_back(CH_B);
              1:       s.push_back(CH_F);
              2:       s.push_back(CH_N);
              3:       s.push_back(CH_R);
              4:       s.push_back(CH_T);
              5:       s.push_back(CH_QUOTE);
              6:       s.push_back(CH_BACKSLASH);
              7:       s.push_back(8'h2F);
              default: s.push_back(8'($urandom));
            endcase
          end else begin
            s.push_back(CH_BACKSLASH);
            s.push_back(CH_U);
            for (j = 0; j < 4; j++) begin
              if ($urandom_range(0, 7) == 0) s.push_back(8'($urandom));
              else s.push_back(hexch[$urandom_range(0, 21)]);
            end
            // truncated \u or dangling backslash at the end of the string
            if (kind == 9) begin
              cut = 1'b1;
              repeat ($urandom_range(1, 5)) void'(s.pop_back());
            end
          end
        end
        if ($urandom_range(0, 3) != 0) s.push_back(CH_QUOTE);
        if (s.size() == 0) s.push_back(8'($urandom));
      end
      for (i = 0; i < s.size(); i++)
        escaped_q.push_back('{b: s[i], last: (i == s.size() - 1), fixed: 1'b0,
                              want_byte: 8'h00, want_valid: 1'b0});
    end
  endtask

  task automatic flag_mismatch(input string what, input int got, input int want);
    errors++;
    if (errors <= 40)
      $display("MISMATCH result %0d %s: got %0h want %0h", n_out, what, got, want);
  endtask

  // Stimulus and end of run
  initial begin : main
    int        k;
    int        g;
    esc_item_t it;
    clear_decoder();
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_byte  <= 8'h00;
    in_last  <= 1'b0;
    in_fixed <= 1'b0;
    in_want  <= '0;
    for (k = 0; k < NUM_ROWS; k++) escaped_q.push_back(directed_rows[k]);
    build_random_strings();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    for (k = 0; k < escaped_q.size(); k++) begin
      it = escaped_q[k];
      g  = hold_off ? 0 : next_gap();
      if (g > 0) begin
        in_valid <= 1'b0;
        repeat (g) @(posedge clk);
      end
      in_valid <= 1'b1;
      in_byte  <= it.b;
      in_last  <= it.last;
      in_fixed <= it.fixed;
      in_want  <= '{data: it.want_byte, valid: it.want_valid, last: it.last};
      do @(posedge clk); while (in_stall);
    end
    in_valid <= 1'b0;
    // wait until every sent item has come back as a result
    while (n_out < escaped_q.size()) @(posedge clk);
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Result side: random stalls plus one long hold-off to back up the block
  initial begin : receiver
    int len;
    int r;
    out_stall <= 1'b0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (!held && n_in >= HOLD_AT) begin
        held      = 1'b1;
        hold_off  = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off  = 1'b0;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 25) begin
          out_stall <= 1'b1;
          len = (r < 3) ? $urandom_range(15, 40) : $urandom_range(1, 4);
        end else begin
          out_stall <= 1'b0;
          len = $urandom_range(1, (r > 90) ? 60 : 8);
        end
        repeat (len) @(posedge clk);
      end
    end
  end

  // Predict on every accepted input item
  always @(posedge clk) begin : take_item
    res_t p;
    if (rst_n && in_valid && !in_stall) begin
      p = unescape_byte(in_byte, in_last);
      unescaped_q.push_back(in_fixed ? in_want : p);
      n_in++;
    end
  end

  // Compare every accepted result with the oldest expectation
  always @(posedge clk) begin : check_result
    res_t w;
    if (rst_n && out_item_valid && !out_stall) begin
      if (unescaped_q.size() == 0) begin
        flag_mismatch("unexpected result", out_byte, 0);
      end else begin
        w = unescaped_q.pop_front();
        if (out_byte !== w.data) flag_mismatch("out_byte", out_byte, w.data);
        if (out_valid !== w.valid) flag_mismatch("out_valid", out_valid, w.valid);
        if (out_last !== w.last) flag_mismatch("out_last", out_last, w.last);
      end
      n_out++;
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cycles, unescaped_q.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

endmodule
